// ----- rtl/l2tpdp_pkg.sv -----
// ----------------------------------------------------------------------------
// l2tpdp_pkg
// Shared types and constants of the L2TPv2 data header parser.
// ----------------------------------------------------------------------------
package l2tpdp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [4:0] MIN_BYTES = 5'd16;

  localparam int unsigned FLAG_TYPE_BIT = 15;
  localparam int unsigned FLAG_LEN_BIT  = 14;
  localparam int unsigned FLAG_SEQ_BIT  = 11;
  localparam int unsigned FLAG_OFF_BIT  = 9;

  localparam logic [7:0] PPP_ADDR = 8'hFF;
  localparam logic [7:0] PPP_CTRL = 8'h03;

  localparam logic CFG_TUNNEL_ID  = 1'b0;
  localparam logic CFG_SESSION_ID = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_CONTROL  = 2'd1,
    VERDICT_MISMATCH = 2'd2,
    VERDICT_DISCARD  = 2'd3
  } verdict_e;

  typedef enum logic [11:0] {
    PH_UDP        = 12'b0000_0000_0001,
    PH_FLAGS      = 12'b0000_0000_0010,
    PH_LENGTH     = 12'b0000_0000_0100,
    PH_TUNNEL     = 12'b0000_0000_1000,
    PH_SESSION    = 12'b0000_0001_0000,
    PH_SEQ        = 12'b0000_0010_0000,
    PH_OFFSIZE    = 12'b0000_0100_0000,
    PH_PAD        = 12'b0000_1000_0000,
    PH_PAY_FIRST  = 12'b0001_0000_0000,
    PH_PAY_SECOND = 12'b0010_0000_0000,
    PH_PAY        = 12'b0100_0000_0000,
    PH_SOFTWARE   = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    verdict_e   verdict;
    logic       packet_end;
    logic [7:0] payload_byte;
    logic       payload_valid;
  } res_t;

  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      res;
  } push_t;

endpackage

// ----- rtl/l2tpdp_parser.sv -----
// ----------------------------------------------------------------------------
// l2tpdp_parser
// Byte-wise header state machine; yields up to two result words per byte.
// ----------------------------------------------------------------------------
module l2tpdp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic [15:0]         tunnel_id_i,
  input  logic [15:0]         session_id_i,
  output l2tpdp_pkg::push_t   push_o
);

  l2tpdp_pkg::phase_e   phase_q, phase_d;
  logic [2:0]           field_q, field_d;
  logic                 seq_q, seq_d;
  logic                 off_q, off_d;
  logic [7:0]           hi_q, hi_d;
  logic [15:0]          skip_q, skip_d;
  logic [4:0]           seen_q, seen_d;
  logic [7:0]           held_q, held_d;
  l2tpdp_pkg::verdict_e pv_q, pv_d;

  logic [15:0]          word;
  l2tpdp_pkg::verdict_e v;
  l2tpdp_pkg::push_t    push;

  assign word = {hi_q, in_byte_i};

  always_comb begin
    phase_d = phase_q;
    field_d = field_q;
    seq_d   = seq_q;
    off_d   = off_q;
    hi_d    = hi_q;
    skip_d  = skip_q;
    seen_d  = seen_q;
    held_d  = held_q;
    pv_d    = pv_q;
    push    = '0;
    v       = l2tpdp_pkg::VERDICT_DISCARD;

    if (in_valid_i) begin
      if (seen_q < l2tpdp_pkg::MIN_BYTES) begin
        seen_d = seen_q + 5'd1;
      end

      unique case (phase_q)
        l2tpdp_pkg::PH_UDP: begin
          if (field_q == 3'd7) begin
            field_d = 3'd0;
            phase_d = l2tpdp_pkg::PH_FLAGS;
          end else begin
            field_d = field_q + 3'd1;
          end
        end
        l2tpdp_pkg::PH_FLAGS: begin
          if (field_q == 3'd0) begin
            hi_d    = in_byte_i;
            field_d = 3'd1;
          end else begin
            field_d = 3'd0;
            seq_d   = word[l2tpdp_pkg::FLAG_SEQ_BIT];
            off_d   = word[l2tpdp_pkg::FLAG_OFF_BIT];
            if (word[l2tpdp_pkg::FLAG_TYPE_BIT]) begin
              pv_d    = l2tpdp_pkg::VERDICT_CONTROL;
              phase_d = l2tpdp_pkg::PH_SOFTWARE;
            end else if (word[l2tpdp_pkg::FLAG_LEN_BIT]) begin
              phase_d = l2tpdp_pkg::PH_LENGTH;
            end else begin
              phase_d = l2tpdp_pkg::PH_TUNNEL;
            end
          end
        end
        l2tpdp_pkg::PH_LENGTH: begin
          if (field_q == 3'd0) begin
            field_d = 3'd1;
          end else begin
            field_d = 3'd0;
            phase_d = l2tpdp_pkg::PH_TUNNEL;
          end
        end
        l2tpdp_pkg::PH_TUNNEL: begin
          if (field_q == 3'd0) begin
            hi_d    = in_byte_i;
            field_d = 3'd1;
          end else begin
            field_d = 3'd0;
            if (word != tunnel_id_i) begin
              pv_d    = l2tpdp_pkg::VERDICT_MISMATCH;
              phase_d = l2tpdp_pkg::PH_SOFTWARE;
            end else begin
              phase_d = l2tpdp_pkg::PH_SESSION;
            end
          end
        end
        l2tpdp_pkg::PH_SESSION: begin
          if (field_q == 3'd0) begin
            hi_d    = in_byte_i;
            field_d = 3'd1;
          end else begin
            field_d = 3'd0;
            if (word != session_id_i) begin
              pv_d    = l2tpdp_pkg::VERDICT_MISMATCH;
              phase_d = l2tpdp_pkg::PH_SOFTWARE;
            end else if (seq_q) begin
              phase_d = l2tpdp_pkg::PH_SEQ;
            end else if (off_q) begin
              phase_d = l2tpdp_pkg::PH_OFFSIZE;
            end else begin
              phase_d = l2tpdp_pkg::PH_PAY_FIRST;
            end
          end
        end
        l2tpdp_pkg::PH_SEQ: begin
          if (field_q == 3'd3) begin
            field_d = 3'd0;
            phase_d = off_q ? l2tpdp_pkg::PH_OFFSIZE : l2tpdp_pkg::PH_PAY_FIRST;
          end else begin
            field_d = field_q + 3'd1;
          end
        end
        l2tpdp_pkg::PH_OFFSIZE: begin
          if (field_q == 3'd0) begin
            hi_d    = in_byte_i;
            field_d = 3'd1;
          end else begin
            field_d = 3'd0;
            skip_d  = word;
            phase_d = (word == 16'd0) ? l2tpdp_pkg::PH_PAY_FIRST : l2tpdp_pkg::PH_PAD;
          end
        end
        l2tpdp_pkg::PH_PAD: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            phase_d = l2tpdp_pkg::PH_PAY_FIRST;
          end
        end
        l2tpdp_pkg::PH_PAY_FIRST: begin
          held_d  = in_byte_i;
          phase_d = l2tpdp_pkg::PH_PAY_SECOND;
        end
        l2tpdp_pkg::PH_PAY_SECOND: begin
          if (!(held_q == l2tpdp_pkg::PPP_ADDR && in_byte_i == l2tpdp_pkg::PPP_CTRL)) begin
            push.cnt = 2'd2;
            push.res[0].payload_valid = 1'b1;
            push.res[0].payload_byte  = held_q;
            push.res[1].payload_valid = 1'b1;
            push.res[1].payload_byte  = in_byte_i;
          end
          phase_d = l2tpdp_pkg::PH_PAY;
        end
        l2tpdp_pkg::PH_PAY: begin
          push.cnt = 2'd1;
          push.res[0].payload_valid = 1'b1;
          push.res[0].payload_byte  = in_byte_i;
        end
        l2tpdp_pkg::PH_SOFTWARE: begin
        end
        default: begin
          phase_d = l2tpdp_pkg::PH_UDP;
        end
      endcase

      if (in_last_i) begin
        if (seen_d < l2tpdp_pkg::MIN_BYTES) begin
          push = '0;
          v    = l2tpdp_pkg::VERDICT_DISCARD;
        end else if (phase_d == l2tpdp_pkg::PH_SOFTWARE) begin
          v = pv_d;
        end else if (phase_d == l2tpdp_pkg::PH_PAY_SECOND) begin
          push.cnt = 2'd1;
          push.res[0].payload_valid = 1'b1;
          push.res[0].payload_byte  = held_d;
          v = l2tpdp_pkg::VERDICT_PASS;
        end else if (phase_d == l2tpdp_pkg::PH_PAY_FIRST || phase_d == l2tpdp_pkg::PH_PAY) begin
          v = l2tpdp_pkg::VERDICT_PASS;
        end else begin
          v = l2tpdp_pkg::VERDICT_DISCARD;
        end

        if (push.cnt == 2'd0) begin
          push.cnt    = 2'd1;
          push.res[0] = '0;
        end
        if (push.cnt == 2'd2) begin
          push.res[1].packet_end = 1'b1;
          push.res[1].verdict    = v;
        end else begin
          push.res[0].packet_end = 1'b1;
          push.res[0].verdict    = v;
        end

        phase_d = l2tpdp_pkg::PH_UDP;
        field_d = 3'd0;
        seq_d   = 1'b0;
        off_d   = 1'b0;
        hi_d    = 8'd0;
        skip_d  = 16'd0;
        seen_d  = 5'd0;
        held_d  = 8'd0;
        pv_d    = l2tpdp_pkg::VERDICT_PASS;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= l2tpdp_pkg::PH_UDP;
      field_q <= 3'd0;
      seq_q   <= 1'b0;
      off_q   <= 1'b0;
      hi_q    <= 8'd0;
      skip_q  <= 16'd0;
      seen_q  <= 5'd0;
      held_q  <= 8'd0;
      pv_q    <= l2tpdp_pkg::VERDICT_PASS;
    end else begin
      phase_q <= phase_d;
      field_q <= field_d;
      seq_q   <= seq_d;
      off_q   <= off_d;
      hi_q    <= hi_d;
      skip_q  <= skip_d;
      seen_q  <= seen_d;
      held_q  <= held_d;
      pv_q    <= pv_d;
    end
  end

endmodule

// ----- rtl/l2tpdp_res_fifo.sv -----
// ----------------------------------------------------------------------------
// l2tpdp_res_fifo
// Result queue: takes up to two words per cycle, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module l2tpdp_res_fifo #(
  parameter int unsigned Depth = l2tpdp_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  l2tpdp_pkg::push_t push_i,
  output logic              space2_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output l2tpdp_pkg::res_t  out_res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] SpaceLimit = CntW'(Depth - 2);

  l2tpdp_pkg::res_t [Depth-1:0] mem_q;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign space2_o    = (cnt_q <= SpaceLimit);
  assign wr_nx       = inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    unique case (push_i.cnt)
      2'd1:    wr_d = wr_nx;
      2'd2:    wr_d = inc(wr_nx);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/l2tp_data_header_parser.sv -----
// ----------------------------------------------------------------------------
// l2tp_data_header_parser
// Strips UDP and L2TPv2 data headers and streams the PPP payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one datagram byte per word, starting at the UDP header;
//   tlast marks the final byte. m_axis carries result words: a payload byte
//   with its valid flag, and on the word with tlast the datagram verdict
//   (pass, control, ID mismatch, discarded).
//   cfg_we_i writes the expected tunnel ID (index 0) or session ID (index 1)
//   at the clock edge; write only while no datagram is in flight.
//   One input byte is taken every cycle while s_axis_tready is high. A
//   result is registered in the result queue before it reaches m_axis.
//   The second payload byte causes two result words (the first byte and
//   itself), or none when the pair is the PPP address/control FF 03.
//   s_axis_tready drops when the result queue has fewer than two free
//   slots, so a stalled receiver stops input after a few words; no word is
//   lost. Reset clears the parser, empties the queue and zeroes both IDs.
// ----------------------------------------------------------------------------
module l2tp_data_header_parser #(
  parameter int unsigned FifoDepth = l2tpdp_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic        m_axis_tlast,   // packet_end
  output logic [2:0]  m_axis_tuser    // [0] payload_valid, [2:1] verdict
);

  logic [15:0]       tunnel_q, session_q;
  logic              in_acc;
  l2tpdp_pkg::push_t push;
  l2tpdp_pkg::res_t  res;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tunnel_q  <= 16'd0;
      session_q <= 16'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == l2tpdp_pkg::CFG_TUNNEL_ID) begin
        tunnel_q <= cfg_data_i;
      end else begin
        session_q <= cfg_data_i;
      end
    end
  end

  l2tpdp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_acc),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .tunnel_id_i  (tunnel_q),
    .session_id_i (session_q),
    .push_o       (push)
  );

  l2tpdp_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space2_o    (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = res.payload_byte;
  assign m_axis_tlast = res.packet_end;
  assign m_axis_tuser = {res.verdict, res.payload_valid};

endmodule
